>>> rtl/qrs_pkg.sv
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ROOT_W         = 34;

    typedef enum logic [1:0] {
        ST_NOT_QUAD = 2'd0,
        ST_NO_REAL  = 2'd1,
        ST_DOUBLE   = 2'd2,
        ST_TWO      = 2'd3
    } root_status_t;

endpackage

>>> rtl/quadratic_root_solver.sv
// Quadratic root solver: each input beat carries signed coefficients a, b, c of
// a*x^2 + b*x + c = 0 and yields one output beat with a status (not quadratic,
// no real roots, double root, two roots) and the roots x1 = (-b - sqrt(d))/(2a)
// and x2 = (-b + sqrt(d))/(2a) in signed fixed point with FRAC_BITS fraction
// bits, truncated toward zero and saturated to 34 bits; roots read zero when
// there are none. The block is fully pipelined and takes one beat per clock while
// the output is not stalled. It has one stage per root bit of the square-root
// recurrence, one stage per quotient bit of the two restoring dividers, plus the
// capture, product, discriminant, numerator and output stages. Backpressure
// on the output stalls the whole pipeline; no beat is lost or repeated.
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // coef_a, coef_b, coef_c from the lowest bit up, zero padded to bytes
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // root_low, root_high from the lowest bit up, zero padded to bytes
    output logic [((2*ROOT_W+7)/8)*8-1:0]          m_tdata,
    // root_status
    output logic [1:0]                             m_tuser
);

    localparam int CW   = COEF_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DW   = 2*CW + 2;         // discriminant width (even)
    localparam int R    = DW/2 + F;         // sqrt result width
    localparam int RW   = R + 3;            // sqrt remainder width
    localparam int NBW  = CW + 1 + F;       // -b * 2^F
    localparam int NW   = CW + 3 + F;       // numerator and quotient width
    localparam int DRW  = CW + 2;           // divider remainder width
    localparam int EW   = (NW > 35) ? NW : 35;
    localparam int OUT_W = ((2*ROOT_W+7)/8)*8;

    logic en;

    // ---------------- stage 0: capture coefficients
    logic                 v0_reg;
    logic signed [CW-1:0] a0_reg, b0_reg, c0_reg;

    // ---------------- stage 1: products
    logic                 v1_reg;
    logic [2*CW-1:0]      b2_1_reg, m_1_reg;
    logic                 add_1_reg, az_1_reg;
    logic signed [CW-1:0] a1_reg, b1_reg;
    logic [CW-1:0]        amag, bmag, cmag;

    // ---------------- square-root pipeline, index 0 loaded from stage 2
    logic                 sv_reg   [0:R];
    logic [RW-1:0]        srem_reg [0:R];
    logic [R-1:0]         sroot_reg[0:R];
    logic [DW-1:0]        srad_reg [0:R];
    root_status_t         sst_reg  [0:R];
    logic signed [NBW-1:0] snb_reg [0:R];
    logic                 sneg_reg [0:R];
    logic [CW:0]          sden_reg [0:R];

    // ---------------- divider pipeline, index 0 loaded from numerator stage
    logic                 qv_reg   [0:NW];
    root_status_t         qst_reg  [0:NW];
    logic [CW:0]          qden_reg [0:NW];
    logic [DRW-1:0]       lrem_reg [0:NW], hrem_reg [0:NW];
    logic [NW-1:0]        lnum_reg [0:NW], hnum_reg [0:NW];
    logic [NW-1:0]        lq_reg   [0:NW], hq_reg   [0:NW];
    logic                 lneg_reg [0:NW], hneg_reg [0:NW];

    // ---------------- output register
    logic                 m_tvalid_reg;
    logic [1:0]           st_out_reg;
    logic [ROOT_W-1:0]    lo_out_reg, hi_out_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = st_out_reg;
    assign m_tdata  = OUT_W'({hi_out_reg, lo_out_reg});

    // stage 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg <= s_tdata[CW-1:0];
            b0_reg <= s_tdata[2*CW-1:CW];
            c0_reg <= s_tdata[3*CW-1:2*CW];
        end
    end

    // stage 1: |b|^2 and |a||c|
    assign amag = a0_reg[CW-1] ? CW'(-a0_reg) : CW'(a0_reg);
    assign bmag = b0_reg[CW-1] ? CW'(-b0_reg) : CW'(b0_reg);
    assign cmag = c0_reg[CW-1] ? CW'(-c0_reg) : CW'(c0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_1_reg  <= (2*CW)'(bmag) * (2*CW)'(bmag);
            m_1_reg   <= (2*CW)'(amag) * (2*CW)'(cmag);
            // 4ac <= 0 when c is zero or signs differ: discriminant adds
            add_1_reg <= (c0_reg == '0) || (a0_reg[CW-1] ^ c0_reg[CW-1]);
            az_1_reg  <= (a0_reg == '0);
            a1_reg    <= a0_reg;
            b1_reg    <= b0_reg;
        end
    end

    // stage 2: discriminant, status, -b*2^F and |2a|
    logic [DW-1:0]         q4, b2x, d_next;
    logic                  dneg;
    root_status_t          st_next;
    logic signed [NBW-1:0] bx;

    always_comb
    begin
        q4   = {m_1_reg, 2'b00};
        b2x  = DW'(b2_1_reg);
        dneg = 1'b0;
        if (add_1_reg)
        begin
            d_next = b2x + q4;
        end
        else if (q4 <= b2x)
        begin
            d_next = b2x - q4;
        end
        else
        begin
            d_next = '0;
            dneg   = 1'b1;
        end
        if (az_1_reg)
        begin
            st_next = ST_NOT_QUAD;
        end
        else if (dneg)
        begin
            st_next = ST_NO_REAL;
        end
        else if (d_next == '0)
        begin
            st_next = ST_DOUBLE;
        end
        else
        begin
            st_next = ST_TWO;
        end
        bx = NBW'(b1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sv_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
            srad_reg[0]  <= d_next;
            sst_reg[0]   <= st_next;
            snb_reg[0]   <= -(bx <<< F);
            sneg_reg[0]  <= a1_reg[CW-1];
            sden_reg[0]  <= a1_reg[CW-1] ? (CW+1)'(-{a1_reg, 1'b0})
                                          : (CW+1)'({a1_reg, 1'b0});
        end
    end

    // square root: one result bit per stage, two radicand bits in
    genvar k;
    generate
        for (k = 0; k < R; k++)
        begin : g_sqrt
            logic [RW-1:0] cand_next, trial_next;
            logic          ge_next;

            always_comb
            begin
                cand_next  = {srem_reg[k][RW-3:0], srad_reg[k][DW-1:DW-2]};
                trial_next = {1'b0, sroot_reg[k], 2'b01};
                ge_next    = (cand_next >= trial_next);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sv_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    sv_reg[k+1] <= sv_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    srem_reg[k+1]  <= ge_next ? cand_next - trial_next : cand_next;
                    sroot_reg[k+1] <= {sroot_reg[k][R-2:0], ge_next};
                    srad_reg[k+1]  <= {srad_reg[k][DW-3:0], 2'b00};
                    sst_reg[k+1]   <= sst_reg[k];
                    snb_reg[k+1]   <= snb_reg[k];
                    sneg_reg[k+1]  <= sneg_reg[k];
                    sden_reg[k+1]  <= sden_reg[k];
                end
            end
        end
    endgenerate

    // numerator stage: -b*2^F -/+ sqrt(d)*2^F, split into sign and magnitude
    logic signed [NW-1:0] nlo, nhi, sx;

    always_comb
    begin
        sx  = NW'($signed({1'b0, sroot_reg[R]}));
        nlo = NW'(snb_reg[R]) - sx;
        nhi = NW'(snb_reg[R]) + sx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            qv_reg[0] <= sv_reg[R];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qst_reg[0]  <= sst_reg[R];
            qden_reg[0] <= sden_reg[R];
            lrem_reg[0] <= '0;
            hrem_reg[0] <= '0;
            lq_reg[0]   <= '0;
            hq_reg[0]   <= '0;
            lnum_reg[0] <= nlo[NW-1] ? NW'(-nlo) : NW'(nlo);
            hnum_reg[0] <= nhi[NW-1] ? NW'(-nhi) : NW'(nhi);
            lneg_reg[0] <= nlo[NW-1] ^ sneg_reg[R];
            hneg_reg[0] <= nhi[NW-1] ^ sneg_reg[R];
        end
    end

    // restoring dividers: one quotient bit per stage, both roots side by side
    genvar j;
    generate
        for (j = 0; j < NW; j++)
        begin : g_div
            logic [DRW-1:0] lc_next, hc_next, dv_next;
            logic           lge_next, hge_next;

            always_comb
            begin
                dv_next  = DRW'(qden_reg[j]);
                lc_next  = {lrem_reg[j][DRW-2:0], lnum_reg[j][NW-1]};
                hc_next  = {hrem_reg[j][DRW-2:0], hnum_reg[j][NW-1]};
                lge_next = (lc_next >= dv_next);
                hge_next = (hc_next >= dv_next);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    qv_reg[j+1] <= 1'b0;
                end
                else if (en)
                begin
                    qv_reg[j+1] <= qv_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lrem_reg[j+1] <= lge_next ? lc_next - dv_next : lc_next;
                    hrem_reg[j+1] <= hge_next ? hc_next - dv_next : hc_next;
                    lq_reg[j+1]   <= {lq_reg[j][NW-2:0], lge_next};
                    hq_reg[j+1]   <= {hq_reg[j][NW-2:0], hge_next};
                    lnum_reg[j+1] <= {lnum_reg[j][NW-2:0], 1'b0};
                    hnum_reg[j+1] <= {hnum_reg[j][NW-2:0], 1'b0};
                    lneg_reg[j+1] <= lneg_reg[j];
                    hneg_reg[j+1] <= hneg_reg[j];
                    qst_reg[j+1]  <= qst_reg[j];
                    qden_reg[j+1] <= qden_reg[j];
                end
            end
        end
    endgenerate

    // output stage: apply sign, saturate to 34 bits, zero when no roots
    logic [EW-1:0]     lqe, hqe;
    logic [ROOT_W-1:0] lo_next, hi_next;
    logic              has_roots;

    always_comb
    begin
        lqe       = EW'(lq_reg[NW]);
        hqe       = EW'(hq_reg[NW]);
        has_roots = (qst_reg[NW] == ST_DOUBLE) || (qst_reg[NW] == ST_TWO);

        if (lneg_reg[NW])
        begin
            lo_next = (lqe > EW'(64'd8589934592)) ? {1'b1, {(ROOT_W-1){1'b0}}}
                                                   : ROOT_W'(-lqe);
        end
        else
        begin
            lo_next = (lqe > EW'(64'd8589934591)) ? {1'b0, {(ROOT_W-1){1'b1}}}
                                                   : ROOT_W'(lqe);
        end

        if (hneg_reg[NW])
        begin
            hi_next = (hqe > EW'(64'd8589934592)) ? {1'b1, {(ROOT_W-1){1'b0}}}
                                                   : ROOT_W'(-hqe);
        end
        else
        begin
            hi_next = (hqe > EW'(64'd8589934591)) ? {1'b0, {(ROOT_W-1){1'b1}}}
                                                   : ROOT_W'(hqe);
        end

        if (!has_roots)
        begin
            lo_next = '0;
            hi_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= qv_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_out_reg <= qst_reg[NW];
            lo_out_reg <= lo_next;
            hi_out_reg <= hi_next;
        end
    end

endmodule
